// ===== src/utoa_pkg.sv =====
// Package for the radix converter: mode codes, widths and digit helpers.
`timescale 1ns / 1ps
`default_nettype none
package utoa_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int IN_VALUE_W = 32;
	localparam int MODE_W = 3;
	localparam int CHAR_W = 7;
	localparam int CNT_W = 6;

	// Digit store: one entry per possible digit, binary being the longest.
	localparam int MAX_DIGITS = IN_VALUE_W;
	localparam int DIG_IW = $clog2(MAX_DIGITS);
	localparam int OCT_DIGITS = (IN_VALUE_W + 2) / 3;
	localparam int HEX_DIGITS = IN_VALUE_W / 4;

	// Binary to BCD conversion: ten decimal digits, four input bits per stage.
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W = 4 * BCD_DIGITS;
	localparam int DD_BITS = 4;
	localparam int DD_STAGES = IN_VALUE_W / DD_BITS;

	typedef enum logic [MODE_W-1:0] {
		MODE_BIN = 3'd0,
		MODE_OCT = 3'd1,
		MODE_DEC = 3'd2,
		MODE_HEXL = 3'd3,
		MODE_HEXU = 3'd4
	} mode_t;

	// Character for one digit value.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
		logic [CHAR_W-1:0] r;
		if (d < 4'd10) begin
			r = 7'd48 + {3'd0, d};
		end else if (upper) begin
			r = 7'd55 + {3'd0, d};
		end else begin
			r = 7'd87 + {3'd0, d};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/utoa_divstep.sv =====
// One pipeline stage of the binary to BCD conversion: four shift and add-three steps.
`timescale 1ns / 1ps
`default_nettype none
module utoa_divstep
	import utoa_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  vin,
	input  wire logic [MODE_W-1:0]     mode_in,
	input  wire logic [IN_VALUE_W-1:0] bin_in,
	input  wire logic [BCD_W-1:0]      bcd_in,
	output logic                       vout,
	output logic [MODE_W-1:0]          mode_out,
	output logic [IN_VALUE_W-1:0]      bin_out,
	output logic [BCD_W-1:0]           bcd_out
);

	logic [IN_VALUE_W-1:0] bin;
	logic [BCD_W-1:0] bcd;

	// The binary word is rotated rather than shifted, so after all stages it
	// is back in its original order and still serves the power-of-two modes.
	always_comb begin
		bin = bin_in;
		bcd = bcd_in;
		for (int s = 0; s < DD_BITS; s++) begin
			for (int k = 0; k < BCD_DIGITS; k++) begin
				if (bcd[4*k +: 4] >= 4'd5) bcd[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
			end
			bcd = {bcd[BCD_W-2:0], bin[IN_VALUE_W-1]};
			bin = {bin[IN_VALUE_W-2:0], bin[IN_VALUE_W-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_out <= mode_in;
			bin_out <= bin;
			bcd_out <= bcd;
		end
	end

endmodule
`default_nettype wire

// ===== src/unsigned_to_ascii_radix_unit.sv =====
// Top level of the unsigned to ASCII radix converter.
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Handshake         Payload
// s_axis   in   tvalid / tready   tdata = {value, mode}
// m_axis   out  tvalid / tready   tdata = {char_count, character}, tlast = last_digit
//
// An accepted word passes an input register and eight conversion stages, each
// taking four bits of the binary to BCD conversion, before it reaches the digit
// serialiser; the serialiser loads it and then writes its first word to the
// output register. Words then leave one a cycle while tready is high; a value of
// n digits gives n words and holds the serialiser until the last is sent, and
// the next value loads in the cycle after its last word.
// Reset clears the valid bits, the serialiser and the output valid.
// While the last stage holds a value and the serialiser is busy the whole
// pipeline holds and tready is low; a stalled output word waits in the output
// register and no word is lost or repeated.
module unsigned_to_ascii_radix_unit
	import utoa_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // mode[2:0], value[34:3], zeros
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // character[6:0], char_count[12:7], zeros
	output logic             m_axis_tlast   // last_digit
);

	// Only the low VALUE_WIDTH bits of the value take part.
	localparam int EW = (VALUE_WIDTH < IN_VALUE_W) ? VALUE_WIDTH : IN_VALUE_W;
	localparam logic [IN_VALUE_W-1:0] VAL_MASK = {IN_VALUE_W{1'b1}} >> (IN_VALUE_W - EW);
	localparam int LAST = DD_STAGES - 1;

	logic [IN_VALUE_W-1:0] in_val;
	logic [MODE_W-1:0] in_mode;
	logic mode_ok;

	logic v_s1;
	logic [MODE_W-1:0] mode_s1;
	logic [IN_VALUE_W-1:0] val_s1;

	logic [DD_STAGES-1:0] dd_v_s;
	logic [MODE_W-1:0] dd_mode_s [DD_STAGES];
	logic [IN_VALUE_W-1:0] dd_bin_s [DD_STAGES];
	logic [BCD_W-1:0] dd_bcd_s [DD_STAGES];

	logic pipe_en;
	logic load;
	logic emit;
	logic last_w;
	logic out_free;
	logic [3*OCT_DIGITS-1:0] oct_ext;
	logic [3:0] ld_dig [MAX_DIGITS];
	logic [CNT_W-1:0] ld_cnt;
	logic [DIG_IW-1:0] rd_idx;

	logic busy_q;
	logic upper_q;
	logic [3:0] dig_q [MAX_DIGITS];
	logic [CNT_W-1:0] cnt_q, idx_q;

	assign in_val = s_axis_tdata[34:3];
	assign in_mode = s_axis_tdata[2:0];
	assign mode_ok = (in_mode == MODE_BIN) || (in_mode == MODE_OCT) ||
		(in_mode == MODE_DEC) || (in_mode == MODE_HEXL) || (in_mode == MODE_HEXU);

	// The pipeline moves unless a converted value is waiting for the serialiser.
	assign pipe_en = !dd_v_s[LAST] || !busy_q;
	assign load = dd_v_s[LAST] && !busy_q;
	assign s_axis_tready = pipe_en;

	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign emit = busy_q && out_free;
	assign last_w = (idx_q == CNT_W'(1));
	assign rd_idx = DIG_IW'(idx_q - CNT_W'(1));

	// Conversion stages; words with an unused mode are taken but already dropped at the input register.
	for (genvar k = 0; k < DD_STAGES; k++) begin : g_dd
		if (k == 0) begin : g_first
			utoa_divstep u_dd (
				.clk(clk), .arst_n(arst_n), .en(pipe_en),
				.vin(v_s1), .mode_in(mode_s1), .bin_in(val_s1), .bcd_in('0),
				.vout(dd_v_s[k]), .mode_out(dd_mode_s[k]),
				.bin_out(dd_bin_s[k]), .bcd_out(dd_bcd_s[k])
			);
		end else begin : g_next
			utoa_divstep u_dd (
				.clk(clk), .arst_n(arst_n), .en(pipe_en),
				.vin(dd_v_s[k-1]), .mode_in(dd_mode_s[k-1]),
				.bin_in(dd_bin_s[k-1]), .bcd_in(dd_bcd_s[k-1]),
				.vout(dd_v_s[k]), .mode_out(dd_mode_s[k]),
				.bin_out(dd_bin_s[k]), .bcd_out(dd_bcd_s[k])
			);
		end
	end

	// Digits of the finished value, least significant first, and their count.
	// A zero value still gives one digit.
	always_comb begin
		oct_ext = (3*OCT_DIGITS)'(dd_bin_s[LAST]);
		for (int i = 0; i < MAX_DIGITS; i++) ld_dig[i] = 4'd0;
		case (dd_mode_s[LAST]) inside
			MODE_BIN: begin
				for (int i = 0; i < MAX_DIGITS; i++) ld_dig[i] = {3'd0, dd_bin_s[LAST][i]};
			end
			MODE_OCT: begin
				for (int i = 0; i < OCT_DIGITS; i++) ld_dig[i] = {1'b0, oct_ext[3*i +: 3]};
			end
			MODE_DEC: begin
				for (int i = 0; i < BCD_DIGITS; i++) ld_dig[i] = dd_bcd_s[LAST][4*i +: 4];
			end
			MODE_HEXL, MODE_HEXU: begin
				for (int i = 0; i < HEX_DIGITS; i++) ld_dig[i] = dd_bin_s[LAST][4*i +: 4];
			end
			default: ;
		endcase
		ld_cnt = CNT_W'(1);
		for (int i = 1; i < MAX_DIGITS; i++) begin
			if (ld_dig[i] != 4'd0) ld_cnt = CNT_W'(i + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			busy_q <= 1'b0;
			idx_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (pipe_en) v_s1 <= s_axis_tvalid && mode_ok;
			if (load) begin
				busy_q <= 1'b1;
				idx_q <= ld_cnt;
			end else if (emit) begin
				idx_q <= idx_q - CNT_W'(1);
				if (last_w) busy_q <= 1'b0;
			end
			if (emit) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			mode_s1 <= in_mode;
			val_s1 <= in_val & VAL_MASK;
		end
		if (load) begin
			for (int i = 0; i < MAX_DIGITS; i++) dig_q[i] <= ld_dig[i];
			cnt_q <= ld_cnt;
			upper_q <= (dd_mode_s[LAST] == MODE_HEXU);
		end
		// Digits go out most significant first; the count rides on the last.
		if (emit) begin
			m_axis_tdata <= {3'd0, (last_w ? cnt_q : CNT_W'(0)),
				digit_char(dig_q[rd_idx], upper_q)};
			m_axis_tlast <= last_w;
		end
	end

endmodule
`default_nettype wire
